// ===== hdl/soh_length_xor_frame_parser_core_macros.svh =====
// Assertion macros shared by the SOH length XOR frame parser RTL.
// Each macro samples on clock and is disabled while reset is high.
`ifndef SOH_LENGTH_XOR_FRAME_PARSER_CORE_MACROS_SVH
`define SOH_LENGTH_XOR_FRAME_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLXFP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLXFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/soh_lxfp_pkg.sv =====
// Types and constants of the SOH length XOR frame parser.
// Used by the step logic, the response skid buffer and the top level.
`timescale 1ns / 1ps

package soh_lxfp_pkg;

   localparam logic [7:0]  SOH_BYTE      = 8'h01;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] POS_HUNT = 2'd0;
   localparam logic [1:0] POS_SOH  = 2'd1;
   localparam logic [1:0] POS_TYPE = 2'd2;
   localparam logic [1:0] POS_DATA = 2'd3;

   localparam logic [1:0] STATUS_BUSY     = 2'd0;
   localparam logic [1:0] STATUS_GOOD     = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

   typedef struct packed {
      logic        in_frame;
      logic [1:0]  byte_position;
      logic [7:0]  bytes_remaining;
      logic [7:0]  running_xor;
      logic [15:0] idle_tick_count;
   } state_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       first_of_frame;
      logic       last_of_frame;
      logic [1:0] frame_status;
   } rsp_type;

endpackage

// ===== hdl/soh_lxfp_step.sv =====
// Next-state and result logic for one beat of the frame parser.
// Purely combinational; depends on soh_lxfp_pkg.
`timescale 1ns / 1ps

module soh_lxfp_step
   import soh_lxfp_pkg::*;
(
   input  state_type   state,
   input  logic        op,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] timeout_ticks,
   output state_type   next_state,
   output logic        emit,
   output rsp_type     result
);

   logic expired;

   assign expired = state.idle_tick_count > timeout_ticks;

   always_comb begin
      next_state = state;
      emit = 1'b0;
      result.frame_byte = rx_byte;
      result.first_of_frame = 1'b0;
      result.last_of_frame = 1'b0;
      result.frame_status = STATUS_BUSY;

      if (op == OP_TICK) begin
         if (state.idle_tick_count != IDLE_MAX) begin
            next_state.idle_tick_count = state.idle_tick_count + 16'd1;
         end
      end else begin
         next_state.idle_tick_count = '0;
         priority if (!state.in_frame || (expired && rx_byte == SOH_BYTE)) begin
            if (rx_byte == SOH_BYTE) begin
               next_state.in_frame = 1'b1;
               next_state.byte_position = POS_SOH;
               next_state.bytes_remaining = '0;
               next_state.running_xor = '0;
               emit = 1'b1;
               result.first_of_frame = 1'b1;
            end
         end else if (expired) begin
            next_state.in_frame = 1'b0;
            next_state.byte_position = POS_HUNT;
            next_state.bytes_remaining = '0;
            next_state.running_xor = '0;
            emit = 1'b1;
            result.last_of_frame = 1'b1;
            result.frame_status = STATUS_TIMEOUT;
         end else if (state.byte_position == POS_HUNT || state.byte_position == POS_SOH) begin
            next_state.running_xor = state.running_xor ^ rx_byte;
            next_state.byte_position = POS_TYPE;
            emit = 1'b1;
         end else if (state.byte_position == POS_TYPE) begin
            next_state.running_xor = state.running_xor ^ rx_byte;
            next_state.bytes_remaining = rx_byte;
            next_state.byte_position = POS_DATA;
            emit = 1'b1;
         end else if (state.bytes_remaining <= 8'd1) begin
            next_state.in_frame = 1'b0;
            next_state.byte_position = POS_HUNT;
            next_state.bytes_remaining = '0;
            next_state.running_xor = '0;
            emit = 1'b1;
            result.last_of_frame = 1'b1;
            result.frame_status = (rx_byte == state.running_xor) ? STATUS_GOOD
                                                                 : STATUS_CHECKSUM;
         end else begin
            next_state.bytes_remaining = state.bytes_remaining - 8'd1;
            next_state.running_xor = state.running_xor ^ rx_byte;
            emit = 1'b1;
         end
      end
   end

endmodule

// ===== hdl/soh_lxfp_rsp_skid.sv =====
// Two-entry output register and skid stage for the parser's result beats.
// Depends on soh_lxfp_pkg for the result type.
`timescale 1ns / 1ps

module soh_lxfp_rsp_skid
   import soh_lxfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rsp_type push_data,
   output logic    push_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff, main_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    main_free;

   assign main_free  = !main_valid_ff || rsp_ready;
   assign push_ready = !skid_valid_ff;
   assign rsp_valid  = main_valid_ff;
   assign rsp_data   = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         main_valid_in = skid_valid_ff || push_valid;
         main_data_in  = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== hdl/soh_length_xor_frame_parser_core.sv =====
// Top level of the SOH length XOR frame parser: state registers, timeout
// register and result path. Depends on soh_lxfp_pkg, soh_lxfp_step,
// soh_lxfp_rsp_skid and the assertion macro header.
//
// The req channel carries one beat per received byte (op 0) or per elapsed
// tick (op 1). Bytes outside a frame other than SOH and all ticks produce
// no rsp beat; every frame byte produces exactly one rsp beat, in order.
// The last rsp beat of a frame carries good, checksum error or timeout; an
// SOH after a timeout starts a new frame and the old one gets no last beat.
// Each req beat is handled in the cycle it is accepted, one per cycle while
// req_ready is high. The rsp side has an output register plus a skid
// stage, so req_ready stays high while one finished beat waits; it drops
// only when both are full and returns as soon as rsp_ready takes a beat.
// The csr channel writes the 16-bit timeout and is always ready; write it
// only while no beat is in flight.
// Synchronous reset clears the frame state, idle count and both result
// stages and loads a timeout of 500 ticks; no clearing pass is needed.
`timescale 1ns / 1ps
`include "soh_length_xor_frame_parser_core_macros.svh"

module soh_length_xor_frame_parser_core
   import soh_lxfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_first_of_frame,
   output logic        rsp_last_of_frame,
   output logic [1:0]  rsp_frame_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_ticks
);

   state_type   state_ff, state_in, step_state;
   logic [15:0] timeout_ticks_ff, timeout_ticks_in;
   logic        req_fire;
   logic        step_emit;
   rsp_type     step_result;
   rsp_type     rsp_data;

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   soh_lxfp_step u_step (
      .state         (state_ff),
      .op            (req_op),
      .rx_byte       (req_rx_byte),
      .timeout_ticks (timeout_ticks_ff),
      .next_state    (step_state),
      .emit          (step_emit),
      .result        (step_result)
   );

   assign state_in         = req_fire ? step_state : state_ff;
   assign timeout_ticks_in = (csr_valid && csr_ready) ? csr_timeout_ticks : timeout_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= '0;
         timeout_ticks_ff <= TIMEOUT_RESET;
      end else begin
         state_ff         <= state_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   soh_lxfp_rsp_skid u_rsp_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_fire && step_emit),
      .push_data  (step_result),
      .push_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_frame_byte     = rsp_data.frame_byte;
   assign rsp_first_of_frame = rsp_data.first_of_frame;
   assign rsp_last_of_frame  = rsp_data.last_of_frame;
   assign rsp_frame_status   = rsp_data.frame_status;

   `SLXFP_ASSERT_NOW(a_stall_only_when_full, !req_ready, rsp_valid,
      "req_ready low while no result is waiting")
   `SLXFP_ASSERT_NOW(a_position_tracks_frame, 1'b1,
      state_ff.in_frame == (state_ff.byte_position != POS_HUNT),
      "byte position disagrees with frame state")
   `SLXFP_ASSERT_NEXT(a_byte_clears_idle, req_fire && req_op == OP_BYTE,
      state_ff.idle_tick_count == 16'd0, "received byte did not clear idle count")
   `SLXFP_ASSERT_NEXT(a_tick_counts, req_fire && req_op == OP_TICK,
      (state_ff.idle_tick_count == $past(state_ff.idle_tick_count) + 16'd1) ||
      (state_ff.idle_tick_count == IDLE_MAX), "tick did not advance idle count")

endmodule
